### rtl/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// hrhp_pkg
// shared types, phase codes and match strings of the request header parser
// ----------------------------------------------------------------------------
`default_nettype none

package hrhp_pkg;

  localparam int unsigned BufferBytesDefault = 2048;

  // result status codes
  localparam logic [1:0] StDone = 2'd0;
  localparam logic [1:0] StBad  = 2'd1;
  localparam logic [1:0] StLong = 2'd2;

  // configuration register indexes
  localparam logic [0:0] RegRequestLimit = 1'd0;

  // parse phases
  typedef enum logic [12:0] {
    PhMethod  = 13'b0_0000_0000_0001,
    PhGap1    = 13'b0_0000_0000_0010,
    PhUrl     = 13'b0_0000_0000_0100,
    PhGap2    = 13'b0_0000_0000_1000,
    PhVer     = 13'b0_0000_0001_0000,
    PhRbad    = 13'b0_0000_0010_0000,
    PhHname   = 13'b0_0000_0100_0000,
    PhHother  = 13'b0_0000_1000_0000,
    PhConnWs  = 13'b0_0001_0000_0000,
    PhConnVal = 13'b0_0010_0000_0000,
    PhClenWs  = 13'b0_0100_0000_0000,
    PhClenVal = 13'b0_1000_0000_0000,
    PhBody    = 13'b1_0000_0000_0000
  } phase_e;

  // url prefix tracking
  typedef enum logic [3:0] {
    UmUndecided = 4'b0001,
    UmSeek      = 4'b0010,
    UmPath      = 4'b0100,
    UmInvalid   = 4'b1000
  } url_mode_e;

  // result payload handed to the output stage
  typedef struct packed {
    logic [1:0]  status;
    logic        is_post;
    logic        keep_alive;
    logic [10:0] url_start;
    logic [10:0] url_length;
    logic        url_is_root;
    logic [15:0] body_length;
    logic [10:0] body_start;
    logic [11:0] request_length;
  } result_t;

  // lower-case fold of letters
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
    return r;
  endfunction

  function automatic logic is_gap(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09);
  endfunction

  // character of each keyword at a position, 0 past its end
  function automatic logic [7:0] chr_get(input logic [3:0] p);
    logic [7:0] r;
    case (p)
      4'd0: r = "g";
      4'd1: r = "e";
      4'd2: r = "t";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] chr_post(input logic [3:0] p);
    logic [7:0] r;
    case (p)
      4'd0: r = "p";
      4'd1: r = "o";
      4'd2: r = "s";
      4'd3: r = "t";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] chr_ver(input logic [3:0] p);
    logic [7:0] r;
    case (p)
      4'd0: r = "h";
      4'd1: r = "t";
      4'd2: r = "t";
      4'd3: r = "p";
      4'd4: r = "/";
      4'd5: r = "1";
      4'd6: r = ".";
      4'd7: r = "1";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] chr_https(input logic [3:0] p);
    logic [7:0] r;
    case (p)
      4'd0: r = "h";
      4'd1: r = "t";
      4'd2: r = "t";
      4'd3: r = "p";
      4'd4: r = "s";
      4'd5: r = ":";
      4'd6: r = "/";
      4'd7: r = "/";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] chr_http(input logic [3:0] p);
    logic [7:0] r;
    case (p)
      4'd0: r = "h";
      4'd1: r = "t";
      4'd2: r = "t";
      4'd3: r = "p";
      4'd4: r = ":";
      4'd5: r = "/";
      4'd6: r = "/";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] chr_conn(input logic [3:0] p);
    logic [7:0] r;
    case (p)
      4'd0: r = "c";
      4'd1: r = "o";
      4'd2: r = "n";
      4'd3: r = "n";
      4'd4: r = "e";
      4'd5: r = "c";
      4'd6: r = "t";
      4'd7: r = "i";
      4'd8: r = "o";
      4'd9: r = "n";
      4'd10: r = ":";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] chr_clen(input logic [3:0] p);
    logic [7:0] r;
    case (p)
      4'd0: r = "c";
      4'd1: r = "o";
      4'd2: r = "n";
      4'd3: r = "t";
      4'd4: r = "e";
      4'd5: r = "n";
      4'd6: r = "t";
      4'd7: r = "-";
      4'd8: r = "l";
      4'd9: r = "e";
      4'd10: r = "n";
      4'd11: r = "g";
      4'd12: r = "t";
      4'd13: r = "h";
      4'd14: r = ":";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] chr_keep(input logic [3:0] p);
    logic [7:0] r;
    case (p)
      4'd0: r = "k";
      4'd1: r = "e";
      4'd2: r = "e";
      4'd3: r = "p";
      4'd4: r = "-";
      4'd5: r = "a";
      4'd6: r = "l";
      4'd7: r = "i";
      4'd8: r = "v";
      4'd9: r = "e";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/hrhp_cfg.sv
// ----------------------------------------------------------------------------
// hrhp_cfg
// apb register file holding the request limit, clamped for the parser
// ----------------------------------------------------------------------------
`default_nettype none

module hrhp_cfg #(
  parameter int unsigned BufferBytes = hrhp_pkg::BufferBytesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [16:0] limit_o
);

  logic [11:0] limit_q;
  logic        hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == hrhp_pkg::RegRequestLimit) && (paddr[1:0] == 2'b00);

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 12'd2048;
    end else if (psel && penable && pwrite && hit) begin
      limit_q <= pwdata[11:0];
    end
  end

  assign prdata = hit ? {20'd0, limit_q} : 32'd0;

  // effective limit: zero acts as one, capped at the buffer size
  always_comb begin
    if (limit_q == 12'd0) begin
      limit_o = 17'd1;
    end else if (17'(limit_q) > 17'(BufferBytes)) begin
      limit_o = 17'(BufferBytes);
    end else begin
      limit_o = 17'(limit_q);
    end
  end

endmodule

`default_nettype wire

### rtl/hrhp_core.sv
// ----------------------------------------------------------------------------
// hrhp_core
// per-byte parse state and next-state logic, one byte a cycle while step_i is high
// ----------------------------------------------------------------------------
`default_nettype none

module hrhp_core (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    step_i,
  input  wire logic [7:0]              byte_i,
  input  wire logic [16:0]             limit_i,
  output logic                         res_valid_o,
  output hrhp_pkg::result_t            res_o
);

  hrhp_pkg::phase_e    phase_q, phase_d;
  hrhp_pkg::url_mode_e umode_q, umode_d;
  logic [3:0]  pos_q, pos_d;
  logic [3:0]  mask_q, mask_d;
  logic        cr_q, cr_d;
  logic [16:0] bpos_q, bpos_d;
  logic        post_q, post_d;
  logic        keep_q, keep_d;
  logic [15:0] len_q, len_d;
  logic [15:0] left_q, left_d;
  logic [10:0] pbeg_q, pbeg_d;
  logic [10:0] psize_q, psize_d;

  logic [7:0]  f;
  logic [3:0]  pb;
  logic        have_res;
  logic [1:0]  st;
  logic [19:0] mul;

  function automatic logic [3:0] bump(input logic [3:0] p);
    return (p < 4'd15) ? p + 4'd1 : 4'd15;
  endfunction

  assign f  = hrhp_pkg::fold(byte_i);
  assign pb = bump(pos_q);
  assign mul = {len_q, 3'b000} + {3'b000, len_q, 1'b0} + 20'(byte_i - 8'h30);

  // next-state logic for one request byte
  always_comb begin
    phase_d = phase_q; umode_d = umode_q; pos_d = pos_q; mask_d = mask_q;
    cr_d = cr_q; post_d = post_q; keep_d = keep_q; len_d = len_q;
    left_d = left_q; pbeg_d = pbeg_q; psize_d = psize_q;
    bpos_d = bpos_q + 17'd1;
    have_res = 1'b0; st = hrhp_pkg::StDone;

    if (phase_q == hrhp_pkg::PhBody) begin
      if (left_q > 16'd1) begin
        left_d = left_q - 16'd1;
      end else begin
        left_d = 16'd0; have_res = 1'b1;
      end
    end else if (cr_q) begin
      cr_d = 1'b0;
      if (byte_i != 8'h0A) begin
        have_res = 1'b1; st = hrhp_pkg::StBad;
      end else begin
        // line end
        phase_d = hrhp_pkg::PhHname; pos_d = 4'd0; mask_d = 4'd3;
        case (phase_q)
          hrhp_pkg::PhVer: begin
            if (!(mask_q[0] && pos_q == 4'd8)) begin
              have_res = 1'b1; st = hrhp_pkg::StBad;
            end
          end
          hrhp_pkg::PhMethod, hrhp_pkg::PhGap1, hrhp_pkg::PhUrl,
          hrhp_pkg::PhGap2, hrhp_pkg::PhRbad: begin
            have_res = 1'b1; st = hrhp_pkg::StBad;
          end
          hrhp_pkg::PhHname: begin
            if (pos_q == 4'd0) begin
              if (len_q == 16'd0) begin
                have_res = 1'b1;
              end else begin
                phase_d = hrhp_pkg::PhBody; left_d = len_q;
              end
            end
          end
          hrhp_pkg::PhConnVal: begin
            if (mask_q[0] && pos_q == 4'd10) keep_d = 1'b1;
          end
          default: ;
        endcase
      end
    end else if (byte_i == 8'h0D) begin
      cr_d = 1'b1;
    end else if (byte_i == 8'h0A) begin
      have_res = 1'b1; st = hrhp_pkg::StBad;
    end else begin
      case (phase_q)
        hrhp_pkg::PhMethod: begin
          if (hrhp_pkg::is_gap(byte_i)) begin
            if (mask_q[0] && pos_q == 4'd3) begin
              post_d = 1'b0; phase_d = hrhp_pkg::PhGap1;
            end else if (mask_q[1] && pos_q == 4'd4) begin
              post_d = 1'b1; phase_d = hrhp_pkg::PhGap1;
            end else begin
              phase_d = hrhp_pkg::PhRbad;
            end
          end else begin
            if (!(pos_q < 4'd3 && f == hrhp_pkg::chr_get(pos_q))) mask_d[0] = 1'b0;
            if (!(pos_q < 4'd4 && f == hrhp_pkg::chr_post(pos_q))) mask_d[1] = 1'b0;
            pos_d = pb;
          end
        end
        hrhp_pkg::PhGap1, hrhp_pkg::PhUrl: begin
          logic [3:0] i;
          logic [3:0] m;
          hrhp_pkg::url_mode_e um;
          i = pos_q; m = mask_q; um = umode_q;
          if (phase_q == hrhp_pkg::PhGap1) begin
            i = 4'd0; m = 4'hC; um = hrhp_pkg::UmUndecided;
          end
          if (hrhp_pkg::is_gap(byte_i)) begin
            if (phase_q == hrhp_pkg::PhUrl) begin
              phase_d = (umode_q == hrhp_pkg::UmPath) ? hrhp_pkg::PhGap2
                                                      : hrhp_pkg::PhRbad;
            end
          end else begin
            phase_d = hrhp_pkg::PhUrl;
            mask_d = m; umode_d = um;
            case (um)
              hrhp_pkg::UmUndecided: begin
                if (i == 4'd0 && byte_i == 8'h2F) begin
                  umode_d = hrhp_pkg::UmPath; pbeg_d = bpos_q[10:0]; psize_d = 11'd1;
                end else begin
                  if (!(i < 4'd7 && f == hrhp_pkg::chr_http(i))) m[2] = 1'b0;
                  if (!(i < 4'd8 && f == hrhp_pkg::chr_https(i))) m[3] = 1'b0;
                  mask_d = m;
                  if ((i == 4'd6 && m[2]) || (i == 4'd7 && m[3])) begin
                    umode_d = hrhp_pkg::UmSeek;
                  end else if (m[3:2] == 2'b00) begin
                    umode_d = hrhp_pkg::UmInvalid;
                  end
                end
              end
              hrhp_pkg::UmSeek: begin
                if (byte_i == 8'h2F) begin
                  umode_d = hrhp_pkg::UmPath; pbeg_d = bpos_q[10:0]; psize_d = 11'd1;
                end
              end
              hrhp_pkg::UmPath: begin
                if (psize_q < 11'd2047) psize_d = psize_q + 11'd1;
              end
              default: ;
            endcase
            pos_d = bump(i);
          end
        end
        hrhp_pkg::PhGap2, hrhp_pkg::PhVer: begin
          if (!(phase_q == hrhp_pkg::PhGap2 && hrhp_pkg::is_gap(byte_i))) begin
            logic [3:0] i;
            i = (phase_q == hrhp_pkg::PhGap2) ? 4'd0 : pos_q;
            phase_d = hrhp_pkg::PhVer;
            mask_d = (phase_q == hrhp_pkg::PhGap2) ? 4'd1 : mask_q;
            if (!(i < 4'd8 && f == hrhp_pkg::chr_ver(i))) mask_d = 4'd0;
            pos_d = bump(i);
          end
        end
        hrhp_pkg::PhHname: begin
          logic [3:0] m;
          m = mask_q;
          if (!(pos_q < 4'd11 && f == hrhp_pkg::chr_conn(pos_q))) m[0] = 1'b0;
          if (!(pos_q < 4'd15 && f == hrhp_pkg::chr_clen(pos_q))) m[1] = 1'b0;
          mask_d = m; pos_d = pb;
          if (m[0] && pb == 4'd11) begin
            phase_d = hrhp_pkg::PhConnWs;
          end else if (m[1] && pb == 4'd15) begin
            phase_d = hrhp_pkg::PhClenWs; len_d = 16'd0;
          end else if (m[1:0] == 2'b00) begin
            phase_d = hrhp_pkg::PhHother;
          end
        end
        hrhp_pkg::PhConnWs, hrhp_pkg::PhConnVal: begin
          if (!(phase_q == hrhp_pkg::PhConnWs && hrhp_pkg::is_gap(byte_i))) begin
            logic [3:0] i;
            i = (phase_q == hrhp_pkg::PhConnWs) ? 4'd0 : pos_q;
            phase_d = hrhp_pkg::PhConnVal;
            mask_d = (phase_q == hrhp_pkg::PhConnWs) ? 4'd1 : mask_q;
            if (!(i < 4'd10 && f == hrhp_pkg::chr_keep(i))) mask_d = 4'd0;
            pos_d = bump(i);
          end
        end
        hrhp_pkg::PhClenWs, hrhp_pkg::PhClenVal: begin
          if (!(phase_q == hrhp_pkg::PhClenWs && hrhp_pkg::is_gap(byte_i))) begin
            if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
              len_d = (mul > 20'd65535) ? 16'hFFFF : mul[15:0];
              phase_d = hrhp_pkg::PhClenVal;
            end else begin
              phase_d = hrhp_pkg::PhHother;
            end
          end
        end
        default: ;
      endcase
    end

    if (!have_res && bpos_d >= limit_i) begin
      have_res = 1'b1; st = hrhp_pkg::StLong;
    end
  end

  // result fields
  always_comb begin
    res_o = '0;
    res_o.status = st;
    res_o.request_length = bpos_d[11:0];
    if (st == hrhp_pkg::StDone) begin
      res_o.is_post     = post_d;
      res_o.keep_alive  = keep_d;
      res_o.url_start   = pbeg_d;
      res_o.url_length  = psize_d;
      res_o.url_is_root = (psize_d == 11'd1);
      res_o.body_length = len_d;
      res_o.body_start  = bpos_d[10:0] - len_d[10:0];
    end
  end
  assign res_valid_o = have_res;

  // state registers, cleared after every result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hrhp_pkg::PhMethod; umode_q <= hrhp_pkg::UmUndecided;
      pos_q <= '0; mask_q <= 4'hF; cr_q <= 1'b0; bpos_q <= '0;
      post_q <= 1'b0; keep_q <= 1'b0; len_q <= '0; left_q <= '0;
      pbeg_q <= '0; psize_q <= '0;
    end else if (step_i) begin
      if (have_res) begin
        phase_q <= hrhp_pkg::PhMethod; umode_q <= hrhp_pkg::UmUndecided;
        pos_q <= '0; mask_q <= 4'hF; cr_q <= 1'b0; bpos_q <= '0;
        post_q <= 1'b0; keep_q <= 1'b0; len_q <= '0; left_q <= '0;
        pbeg_q <= '0; psize_q <= '0;
      end else begin
        phase_q <= phase_d; umode_q <= umode_d; pos_q <= pos_d; mask_q <= mask_d;
        cr_q <= cr_d; bpos_q <= bpos_d; post_q <= post_d; keep_q <= keep_d;
        len_q <= len_d; left_q <= left_d; pbeg_q <= pbeg_d; psize_q <= psize_d;
      end
    end
  end

`ifndef SYNTH
  a_pos_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !have_res |-> bpos_d < limit_i)
    else $error("byte count passed the limit");
  a_body_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == hrhp_pkg::PhBody |-> left_q != 16'd0)
    else $error("body phase with nothing left");
  a_cr_not_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == hrhp_pkg::PhBody |-> !cr_q)
    else $error("pending cr in body");
`endif

endmodule

`default_nettype wire

### rtl/hrhp_out.sv
// ----------------------------------------------------------------------------
// hrhp_out
// result register with one skid entry so the input keeps flowing while the skid is empty
// ----------------------------------------------------------------------------
`default_nettype none

module hrhp_out (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire hrhp_pkg::result_t in_i,
  output logic                   space_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output hrhp_pkg::result_t      out_o
);

  hrhp_pkg::result_t main_q, skid_q;
  logic main_v_q, skid_v_q;
  logic pop;

  assign pop         = main_v_q && out_ready_i;
  assign space_o     = !skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_o       = main_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0; skid_v_q <= 1'b0;
    end else begin
      if (!main_v_q || pop) begin
        main_v_q <= skid_v_q || in_valid_i;
        skid_v_q <= skid_v_q && in_valid_i;
      end else if (in_valid_i) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (!main_v_q || pop) begin
      if (skid_v_q) begin
        main_q <= skid_q;
        if (in_valid_i) skid_q <= in_i;
      end else begin
        main_q <= in_i;
      end
    end else if (in_valid_i) begin
      skid_q <= in_i;
    end
  end

`ifndef SYNTH
  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q) else $error("skid full with empty main");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !pop |-> !in_valid_i) else $error("result dropped");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    main_v_q && !out_ready_i |=> main_v_q && $stable(main_q))
    else $error("result changed while stalled");
`endif

endmodule

`default_nettype wire

### rtl/http_request_header_parser.sv
// ----------------------------------------------------------------------------
// http_request_header_parser
// byte-stream http/1.1 request parser with one result per request
// ----------------------------------------------------------------------------
// One request byte is taken per clock: each byte is registered through the
// single parse stage and the result lands in an output register backed by a
// one-entry skid buffer, so input stalls only when both hold results that
// have not been taken. The ending byte's result is registered in the output
// register or the skid entry; no clearing pass is needed after reset.
`default_nettype none

module http_request_header_parser #(
  parameter int unsigned BufferBytes = hrhp_pkg::BufferBytesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        data_valid_i,
  output logic             data_ready_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             result_valid_o,
  input  wire logic        result_ready_i,
  output logic [1:0]       status_o,
  output logic             is_post_o,
  output logic             keep_alive_o,
  output logic [10:0]      url_start_o,
  output logic [10:0]      url_length_o,
  output logic             url_is_root_o,
  output logic [15:0]      body_length_o,
  output logic [10:0]      body_start_o,
  output logic [11:0]      request_length_o
);

  logic [16:0]       limit;
  logic              step, res_valid, space;
  hrhp_pkg::result_t res, res_out;

  hrhp_cfg #(.BufferBytes(BufferBytes)) u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .limit_o(limit)
  );

  assign data_ready_o = space;
  assign step         = data_valid_i && space;

  hrhp_core u_core (
    .clk_i, .rst_ni, .step_i(step), .byte_i(data_byte_i), .limit_i(limit),
    .res_valid_o(res_valid), .res_o(res)
  );

  hrhp_out u_out (
    .clk_i, .rst_ni, .in_valid_i(step && res_valid), .in_i(res), .space_o(space),
    .out_valid_o(result_valid_o), .out_ready_i(result_ready_i), .out_o(res_out)
  );

  assign status_o         = res_out.status;
  assign is_post_o        = res_out.is_post;
  assign keep_alive_o     = res_out.keep_alive;
  assign url_start_o      = res_out.url_start;
  assign url_length_o     = res_out.url_length;
  assign url_is_root_o    = res_out.url_is_root;
  assign body_length_o    = res_out.body_length;
  assign body_start_o     = res_out.body_start;
  assign request_length_o = res_out.request_length;

`ifndef SYNTH
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> status_o != 2'd3) else $error("bad status code");
  a_bad_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != hrhp_pkg::StDone |-> body_length_o == 16'd0)
    else $error("fields set on failed request");
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> request_length_o != 12'd0) else $error("empty request");
`endif

endmodule

`default_nettype wire
